// ----- src/kt_pkg.sv -----
// ----------------------------------------------------------------------------
// kt_pkg
// shared constants, codes and types of the keyed slot table
// ----------------------------------------------------------------------------
`default_nettype none

package kt_pkg;

    localparam int CAPACITY   = 16;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SLOT_IDX_W = 4;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_FIND   = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_NOPARENT  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] parent;
        logic [31:0]        info;
    } t_slot;

    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_slot data;
    } t_slot_wr;

endpackage

`default_nettype wire

// ----- src/kt_if.sv -----
// ----------------------------------------------------------------------------
// kt_req_if / kt_rsp_if
// valid/ready channels for table requests and responses
// ----------------------------------------------------------------------------
`default_nettype none

interface kt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] key;
    logic signed [31:0] parent_key;
    logic [31:0]        info_word;

    modport source (output valid, action, key, parent_key, info_word, input ready);
    modport sink   (input valid, action, key, parent_key, info_word, output ready);
endinterface

interface kt_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [3:0]         slot_index;
    logic signed [31:0] found_parent;
    logic [31:0]        found_info;

    modport source (output valid, status, slot_index, found_parent, found_info, input ready);
    modport sink   (input valid, status, slot_index, found_parent, found_info, output ready);
endinterface

`default_nettype wire

// ----- src/keyed_table_with_tombstone_compaction_top.sv -----
// ----------------------------------------------------------------------------
// keyed_table_with_tombstone_compaction_top
// linear keyed table with tombstone delete and compaction on a full insert
// ----------------------------------------------------------------------------
// sequence: find, delete and insert scan the filled slots, then decide and
//   respond; an insert into a full table first runs a compaction pass over
//   the filled slots; unused action codes go straight to the response
// throughput: one transaction at a time, set by the single slot memory read
//   port that the scan and compaction passes walk one slot per cycle
// reset: synchronous active-low i_rst_n empties the table (busy flags and fill
//   count cleared); slot contents are not cleared and need no clearing pass
`default_nettype none

module keyed_table_with_tombstone_compaction_top import kt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kt_req_if.sink    i_req,
    kt_rsp_if.source  o_rsp
);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_COMPACT = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_DECIDE  = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    // control state
    logic [2:0]          r_state, n_state;
    t_cnt                r_ptr, n_ptr;       // read pointer of the current pass
    logic                r_rd_vld, n_rd_vld; // read data in flight is valid
    t_cnt                r_fill, n_fill;     // filled slots, busy or tombstoned
    t_cnt                r_wcnt, n_wcnt;     // compaction write pointer
    logic [CAPACITY-1:0] r_busy, n_busy;
    logic                r_khit, n_khit;     // key found in a busy slot
    logic                r_phit, n_phit;     // parent found in a busy slot
    logic                r_out_vld, n_out_vld;

    // payload state
    logic [1:0]              r_act;
    logic signed [31:0]      r_key;
    logic signed [31:0]      r_par;
    logic [31:0]             r_info;
    t_idx                    r_rd_idx;
    t_idx                    r_kidx;
    logic signed [31:0]      r_kpar;
    logic [31:0]             r_kinfo;
    logic [2:0]              r_res_st,   n_res_st;
    t_idx                    r_res_idx,  n_res_idx;
    logic signed [31:0]      r_res_par,  n_res_par;
    logic [31:0]             r_res_info, n_res_info;
    logic [2:0]              r_out_st;
    logic [SLOT_IDX_W-1:0]   r_out_idx;
    logic signed [31:0]      r_out_par;
    logic [31:0]             r_out_info;

    // shared slot memory
    t_slot_wr slot_wr;
    t_slot    rd_data;
    t_idx     rd_addr;
    logic     issue;
    logic     pass_end;
    logic     rd_busy;
    logic     out_free;
    logic     load_out;
    logic     take_in;

    assign rd_addr  = r_ptr[IDX_W-1:0];
    assign issue    = ((r_state == S_SCAN) || (r_state == S_COMPACT)) && (r_ptr < r_fill);
    assign pass_end = !issue && !r_rd_vld;
    assign rd_busy  = r_rd_vld && r_busy[r_rd_idx];
    assign out_free = !r_out_vld || o_rsp.ready;
    assign load_out = (r_state == S_DONE) && out_free;
    assign take_in  = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE);

    kt_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_wr      (slot_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_rd_vld   = issue;
        n_fill     = r_fill;
        n_wcnt     = r_wcnt;
        n_busy     = r_busy;
        n_khit     = r_khit;
        n_phit     = r_phit;
        n_res_st   = r_res_st;
        n_res_idx  = r_res_idx;
        n_res_par  = r_res_par;
        n_res_info = r_res_info;

        slot_wr.en   = 1'b0;
        slot_wr.addr = r_wcnt[IDX_W-1:0];
        slot_wr.data = rd_data;

        if (issue) begin
            n_ptr = r_ptr + t_cnt'(1);
        end

        case (r_state)
            S_IDLE: begin
                n_ptr  = '0;
                n_wcnt = '0;
                n_khit = 1'b0;
                n_phit = 1'b0;
                if (take_in) begin
                    if (i_req.action == ACT_INSERT) begin
                        n_state = (r_fill >= t_cnt'(CAPACITY)) ? S_COMPACT : S_SCAN;
                    end else if (i_req.action == ACT_FIND || i_req.action == ACT_DELETE) begin
                        n_state = S_SCAN;
                    end else begin
                        // unused action code answers not found
                        n_res_st   = ST_NOTFOUND;
                        n_res_idx  = '0;
                        n_res_par  = '0;
                        n_res_info = '0;
                        n_state    = S_DONE;
                    end
                end
            end

            S_COMPACT: begin
                // move each busy slot down to the write pointer, order kept
                if (rd_busy) begin
                    slot_wr.en     = 1'b1;
                    n_busy[r_wcnt[IDX_W-1:0]] = 1'b1;
                    n_wcnt         = r_wcnt + t_cnt'(1);
                end
                if (pass_end) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (t_cnt'(i) >= r_wcnt) begin
                            n_busy[i] = 1'b0;
                        end
                    end
                    n_fill = r_wcnt;
                    n_ptr  = '0;
                    if (r_wcnt != r_fill) begin
                        n_state = S_SCAN;
                    end else begin
                        n_res_st   = ST_FULL;
                        n_res_idx  = '0;
                        n_res_par  = '0;
                        n_res_info = '0;
                        n_state    = S_DONE;
                    end
                end
            end

            S_SCAN: begin
                // first busy match only; parent looked up in the same pass
                if (rd_busy && !r_khit && rd_data.key == r_key) begin
                    n_khit = 1'b1;
                end
                if (rd_busy && rd_data.key == r_par) begin
                    n_phit = 1'b1;
                end
                if (pass_end) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_res_st   = ST_NOTFOUND;
                n_res_idx  = '0;
                n_res_par  = '0;
                n_res_info = '0;
                n_state    = S_DONE;
                case (r_act)
                    ACT_INSERT: begin
                        if (r_khit) begin
                            n_res_st = ST_DUP;
                        end else if (r_par != '0 && !r_phit) begin
                            n_res_st = ST_NOPARENT;
                        end else begin
                            slot_wr.en   = 1'b1;
                            slot_wr.addr = r_fill[IDX_W-1:0];
                            slot_wr.data = '{key: r_key, parent: r_par, info: r_info};
                            n_busy[r_fill[IDX_W-1:0]] = 1'b1;
                            n_fill    = r_fill + t_cnt'(1);
                            n_res_st  = ST_OK;
                            n_res_idx = r_fill[IDX_W-1:0];
                        end
                    end
                    ACT_FIND: begin
                        if (r_khit) begin
                            n_res_st   = ST_OK;
                            n_res_idx  = r_kidx;
                            n_res_par  = r_kpar;
                            n_res_info = r_kinfo;
                        end
                    end
                    ACT_DELETE: begin
                        if (r_khit) begin
                            // tombstone: fill count stays
                            n_busy[r_kidx] = 1'b0;
                            n_res_st       = ST_OK;
                            n_res_idx      = r_kidx;
                        end
                    end
                    default: begin
                        n_res_st = ST_NOTFOUND;
                    end
                endcase
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register: new response or drain on a taken transaction
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_rd_vld  <= 1'b0;
            r_fill    <= '0;
            r_wcnt    <= '0;
            r_busy    <= '0;
            r_khit    <= 1'b0;
            r_phit    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_rd_vld  <= n_rd_vld;
            r_fill    <= n_fill;
            r_wcnt    <= n_wcnt;
            r_busy    <= n_busy;
            r_khit    <= n_khit;
            r_phit    <= n_phit;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_act  <= i_req.action;
            r_key  <= i_req.key;
            r_par  <= i_req.parent_key;
            r_info <= i_req.info_word;
        end
        r_rd_idx <= rd_addr;
        // capture the matching slot on the first hit of the scan
        if (r_state == S_SCAN && rd_busy && !r_khit && rd_data.key == r_key) begin
            r_kidx  <= r_rd_idx;
            r_kpar  <= rd_data.parent;
            r_kinfo <= rd_data.info;
        end
        r_res_st   <= n_res_st;
        r_res_idx  <= n_res_idx;
        r_res_par  <= n_res_par;
        r_res_info <= n_res_info;
        if (load_out) begin
            r_out_st   <= r_res_st;
            r_out_idx  <= SLOT_IDX_W'(r_res_idx);
            r_out_par  <= r_res_par;
            r_out_info <= r_res_info;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out_st;
    assign o_rsp.slot_index   = r_out_idx;
    assign o_rsp.found_parent = r_out_par;
    assign o_rsp.found_info   = r_out_info;

endmodule

`default_nettype wire

// ----- src/kt_slot_ram.sv -----
// ----------------------------------------------------------------------------
// kt_slot_ram
// slot storage: key, parent and info, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module kt_slot_ram import kt_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_slot_wr i_wr,
    input  wire t_idx     i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [CAPACITY];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- dv/kt_table_checker.sv -----
// ----------------------------------------------------------------------------
// kt_table_checker
// watches the request and response channels of the keyed slot table, keeps
// its own copy of the table, and compares every response with the reply
// predicted from the requests
// ----------------------------------------------------------------------------
`default_nettype none

module kt_table_checker import kt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    kt_req_if              i_req_mon,
    kt_rsp_if              i_rsp_mon,
    output int unsigned    o_fail_count,
    output int unsigned    o_pending
);

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         slot_index;
        logic signed [31:0] found_parent;
        logic [31:0]        found_info;
    } t_table_reply;

    // shadow copy of the table
    bit          held       [CAPACITY];
    logic [31:0] key_mem    [CAPACITY];
    logic [31:0] parent_mem [CAPACITY];
    logic [31:0] info_mem   [CAPACITY];
    int          fill_cnt;

    t_table_reply reply_q [$];

    // lowest busy slot holding k, CAPACITY when none
    function automatic int first_held(logic [31:0] k);
        for (int s = 0; s < fill_cnt; s++) begin
            if (held[s] && key_mem[s] == k) begin
                return s;
            end
        end
        return CAPACITY;
    endfunction

    function automatic t_table_reply apply_table_op(logic [1:0] act, logic [31:0] k,
                                                    logic [31:0] par, logic [31:0] inf);
        t_table_reply r;
        int s;
        int w;
        bit room;
        r = '0;
        r.status = ST_NOTFOUND;
        case (act)
            ACT_INSERT: begin
                room = 1'b1;
                if (fill_cnt >= CAPACITY) begin
                    // squeeze out tombstones, busy slots keep their order
                    w = 0;
                    for (s = 0; s < fill_cnt; s++) begin
                        if (held[s]) begin
                            held[w]       = 1'b1;
                            key_mem[w]    = key_mem[s];
                            parent_mem[w] = parent_mem[s];
                            info_mem[w]   = info_mem[s];
                            w++;
                        end
                    end
                    room = (w != fill_cnt);
                    for (s = w; s < CAPACITY; s++) begin
                        held[s] = 1'b0;
                    end
                    fill_cnt = w;
                end
                if (!room) begin
                    r.status = ST_FULL;
                end else if (first_held(k) < CAPACITY) begin
                    r.status = ST_DUP;
                end else if (par != 0 && first_held(par) >= CAPACITY) begin
                    r.status = ST_NOPARENT;
                end else begin
                    s             = fill_cnt;
                    held[s]       = 1'b1;
                    key_mem[s]    = k;
                    parent_mem[s] = par;
                    info_mem[s]   = inf;
                    fill_cnt      = s + 1;
                    r.status      = ST_OK;
                    r.slot_index  = s[SLOT_IDX_W-1:0];
                end
            end
            ACT_FIND: begin
                s = first_held(k);
                if (s < CAPACITY) begin
                    r.status       = ST_OK;
                    r.slot_index   = s[SLOT_IDX_W-1:0];
                    r.found_parent = parent_mem[s];
                    r.found_info   = info_mem[s];
                end
            end
            ACT_DELETE: begin
                s = first_held(k);
                if (s < CAPACITY) begin
                    held[s]      = 1'b0;
                    r.status     = ST_OK;
                    r.slot_index = s[SLOT_IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_table_reply want;
        if (!i_rst_n) begin
            for (int s = 0; s < CAPACITY; s++) begin
                held[s] = 1'b0;
            end
            fill_cnt = 0;
            reply_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (reply_q.size() == 0) begin
                    $error("response transaction with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp_mon.status));
                    check_field("slot_index", 32'(want.slot_index),
                                32'(i_rsp_mon.slot_index));
                    check_field("found_parent", want.found_parent, i_rsp_mon.found_parent);
                    check_field("found_info", want.found_info, i_rsp_mon.found_info);
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                reply_q.insert(reply_q.size(),
                               apply_table_op(i_req_mon.action, i_req_mon.key,
                                              i_req_mon.parent_key, i_req_mon.info_word));
            end
        end
        o_pending <= reply_q.size();
    end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives insert, find, delete and unused-code transactions into the keyed slot table with
// random gaps and response back-pressure; a side checker predicts every reply
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import kt_pkg::*; ();

    // action code with no operation behind it, must answer not found
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS    = 950;
    localparam int POOL_SIZE      = 20;
    localparam int LONG_HOLD      = 400;
    localparam int PRESSURE_AT    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    // worst case accept-to-response: full scan plus a compaction pass
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 10;

    logic clk = 1'b0;
    logic rst_n;

    kt_req_if req ();
    kt_rsp_if rsp ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned accepted_reqs;
    int unsigned idle_cycles;
    bit          long_hold_done;

    // small key pool so that finds, deletes, duplicates and parents hit often
    logic [31:0] key_pool [POOL_SIZE];

    always #4 clk = ~clk;

    keyed_table_with_tombstone_compaction_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    kt_table_checker CHECKER (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_mon    (req),
        .i_rsp_mon    (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idling on both sides, with quiet windows and a quiet tail
    function automatic bit idling_allowed();
        return (accepted_reqs < TOTAL_ITEMS - 100) && ((accepted_reqs / 64) % 4 != 3);
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 85) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_parent();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return '0;
        end else if (roll < 85) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    // one request transaction; called and returns at a falling edge
    task automatic send_op(logic [1:0] act, logic [31:0] k, logic [31:0] par,
                           logic [31:0] inf);
        if (idling_allowed() && $urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.action     <= act;
        req.key        <= k;
        req.parent_key <= par;
        req.info_word  <= inf;
        @(posedge clk);
        while (!req.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // transactions accepted so far, used by the pacing logic
    always @(posedge clk) begin
        if (!rst_n) begin
            accepted_reqs <= 0;
        end else if (req.valid && req.ready) begin
            accepted_reqs <= accepted_reqs + 1;
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // response side: random stall bursts, plus one long hold-off so the
    // block backs up and holds off its request channel
    initial begin
        int hold;
        hold           = 0;
        long_hold_done = 1'b0;
        rsp.ready      = 1'b0;
        forever begin
            @(negedge clk);
            if (rst_n && !long_hold_done && accepted_reqs >= PRESSURE_AT) begin
                long_hold_done = 1'b1;
                hold           = LONG_HOLD;
            end else if (hold == 0 && idling_allowed() && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 17);
            end
            if (hold > 0) begin
                rsp.ready <= 1'b0;
                hold--;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial begin
        int mix;
        int roll;
        int ins_pct;
        int find_pct;
        int del_pct;
        logic [1:0] act;

        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.action     = ACT_INSERT;
        req.key        = '0;
        req.parent_key = '0;
        req.info_word  = '0;

        // extremes and a zero key in the pool, the rest random
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0001;
        key_pool[4] = 32'h0000_0000;
        for (int i = 5; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // extreme keys and info words, parent pointing at a held key
        send_op(ACT_INSERT, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
        send_op(ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        // held key is reported as duplicate before the parent is looked at
        send_op(ACT_INSERT, 32'h8000_0000, 32'h1234_5678, 32'h1);
        // nonzero parent that nobody holds
        send_op(ACT_INSERT, 32'h5, 32'd99, 32'h2);
        send_op(ACT_FIND, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_op(ACT_FIND, 32'd12345, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // unused action code changes nothing
        send_op(ACT_UNUSED, 32'h7FFF_FFFF, 32'h0, 32'h0);
        // fill the rest of the table
        for (int i = 0; i < CAPACITY - 2; i++) begin
            send_op(ACT_INSERT, 32'd100 + i, 32'h7FFF_FFFF, $urandom());
        end
        // full with no tombstone to reclaim
        send_op(ACT_INSERT, 32'd200, 32'h0, 32'h3);
        // delete leaves a tombstone; a second delete misses
        send_op(ACT_DELETE, 32'h8000_0000, 32'h0, 32'h0);
        send_op(ACT_DELETE, 32'h8000_0000, 32'h0, 32'h0);
        // full insert compacts, then the deleted parent is missing
        send_op(ACT_INSERT, 32'd201, 32'h8000_0000, 32'h4);
        // the slot freed by compaction takes the next insert
        send_op(ACT_INSERT, 32'd202, 32'h0, 32'hA5A5_5A5A);

        // ---- random part ----
        // blocks of insert-heavy, balanced and delete-heavy traffic so the
        // table keeps filling, tombstoning and compacting
        for (int n = 0; n < TOTAL_ITEMS - 26; n++) begin
            if (n % 40 == 0) begin
                mix = $urandom_range(0, 2);
            end
            case (mix)
                0:       begin ins_pct = 65; find_pct = 15; del_pct = 15; end
                1:       begin ins_pct = 40; find_pct = 25; del_pct = 30; end
                default: begin ins_pct = 20; find_pct = 25; del_pct = 50; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) begin
                act = ACT_INSERT;
            end else if (roll < ins_pct + find_pct) begin
                act = ACT_FIND;
            end else if (roll < ins_pct + find_pct + del_pct) begin
                act = ACT_DELETE;
            end else begin
                act = ACT_UNUSED;
            end
            send_op(act, pick_key(), pick_parent(), $urandom());
        end
        req.valid <= 1'b0;

        // drain outstanding replies, then give stray responses time to show
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
